### design/twfes_pkg.sv
// ============================================================================
// twfes_pkg
// Shared widths, sideband type and helpers for the tile water flow and
// erosion step pipeline.
// ============================================================================
`default_nettype none

package twfes_pkg;

    localparam int DIR_N        = 8;   // neighbour directions E,NE,N,NW,W,SW,S,SE
    localparam int DIR_W        = 3;
    localparam int ELEV_W       = 8;
    localparam int WGT_W        = 9;   // 1 + 255 at most
    localparam int SUM_W        = 12;  // 8 * 256 at most
    localparam int DRAW_W       = 16;
    localparam int EROS_W       = 10;
    localparam int REM_STG      = 4;   // remainder stages
    localparam int BITS_PER_STG = DRAW_W / REM_STG;

    localparam logic [ELEV_W-1:0] SAT_MAX = 8'hFF;

    typedef logic [ELEV_W-1:0] level_t;

    // Per-item data that rides alongside the remainder unit
    typedef struct packed {
        level_t                         own_elev;
        level_t                         own_water;
        logic [DIR_N*ELEV_W-1:0]        nbr_elev;
        logic [DIR_N*ELEV_W-1:0]        nbr_water;
        logic [DIR_N-1:0]               present;
        logic                           ero_ok;
        logic                           flow_ok;
        logic [DIR_N-1:0][SUM_W-1:0]    cum;
    } side_t;

    // Surface height, saturated at the top of the byte range
    function automatic level_t sat_surface(level_t elev, level_t water);
        logic [ELEV_W:0] sum;
        sum = {1'b0, elev} + {1'b0, water};
        return sum[ELEV_W] ? SAT_MAX : sum[ELEV_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/twfes_rem_pipe.sv
// ============================================================================
// twfes_rem_pipe
// Pipelined restoring remainder: draw modulo weight total, a few quotient
// bits per stage, with the item's sideband carried in step.
// ============================================================================
`default_nettype none

module twfes_rem_pipe (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [twfes_pkg::DRAW_W-1:0]  in_num,
    input  wire logic [twfes_pkg::SUM_W-1:0]   in_div,
    input  wire twfes_pkg::side_t              in_side,
    output logic                               out_valid,
    output logic [twfes_pkg::SUM_W-1:0]        out_rem,
    output twfes_pkg::side_t                   out_side
);
    import twfes_pkg::*;

    logic [REM_STG-1:0] vld_reg;
    logic [SUM_W-1:0]   rem_reg  [REM_STG];
    logic [SUM_W-1:0]   div_reg  [REM_STG];
    logic [DRAW_W-1:0]  num_reg  [REM_STG];
    side_t              side_reg [REM_STG];

    // One restoring step: shift in a dividend bit, subtract when it fits
    function automatic logic [SUM_W-1:0] rem_step(logic [SUM_W-1:0] rem,
                                                  logic bit_in,
                                                  logic [SUM_W-1:0] div);
        logic [SUM_W:0] trial;
        trial = {rem, bit_in};
        if (trial >= {1'b0, div})
        begin
            trial = trial - {1'b0, div};
        end
        return trial[SUM_W-1:0];
    endfunction

    for (genvar g = 0; g < REM_STG; g++)
    begin : g_stg
        logic              v_in;
        logic [SUM_W-1:0]  r_in;
        logic [SUM_W-1:0]  d_in;
        logic [DRAW_W-1:0] n_in;
        side_t             s_in;
        logic [SUM_W-1:0]  r_next;
        logic [DRAW_W-1:0] n_next;

        if (g == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign d_in = in_div;
            assign n_in = in_num;
            assign s_in = in_side;
        end
        else
        begin : g_rest
            assign v_in = vld_reg[g-1];
            assign r_in = rem_reg[g-1];
            assign d_in = div_reg[g-1];
            assign n_in = num_reg[g-1];
            assign s_in = side_reg[g-1];
        end

        // Work off this stage's share of dividend bits
        always_comb
        begin
            r_next = r_in;
            n_next = n_in;
            for (int k = 0; k < BITS_PER_STG; k++)
            begin
                r_next = rem_step(r_next, n_next[DRAW_W-1], d_in);
                n_next = {n_next[DRAW_W-2:0], 1'b0};
            end
        end

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else
            begin
                vld_reg[g] <= v_in;
            end
        end

        // Advance the payload
        always_ff @(posedge clk)
        begin
            rem_reg[g]  <= r_next;
            num_reg[g]  <= n_next;
            div_reg[g]  <= d_in;
            side_reg[g] <= s_in;
        end
    end

    assign out_valid = vld_reg[REM_STG-1];
    assign out_rem   = rem_reg[REM_STG-1];
    assign out_side  = side_reg[REM_STG-1];

endmodule

`default_nettype wire

### design/tile_water_flow_erosion_step.sv
// ============================================================================
// tile_water_flow_erosion_step
// Settles one map tile per beat: weights the eight directions by surface
// drop, picks one by draw modulo weight total and, when the tile has water
// and the weight total is not zero, moves one unit of water and possibly one unit of soil.
// ============================================================================
//
//  Channel  | Handshake             | Carries
//  ---------+-----------------------+------------------------------------------
//  input    | start, busy           | own_*, neighbour_*, flow_draw, erosion_draw
//  config   | cfg_valid, cfg_ready  | erosion_per_mille
//  result   | done (one-cycle)      | new_own_*, flowed, flow_direction, ...
//
//  A new tile is taken every cycle; busy stays low.
//  The pipeline stages are weights, prefix sums, four remainder stages (four
//  dividend bits each) and the pick/update stage that drives the outputs.
//  Reset clears the valid bits and the erosion threshold (never erode).
//  The receiver takes every result the cycle it shows; nothing stalls.
//
`default_nettype none

module tile_water_flow_erosion_step (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [twfes_pkg::EROS_W-1:0]  erosion_per_mille,
    input  wire logic [7:0]                    own_elevation,
    input  wire logic [7:0]                    own_water,
    input  wire logic [63:0]                   neighbour_elevations,
    input  wire logic [63:0]                   neighbour_waters,
    input  wire logic [7:0]                    neighbour_present,
    input  wire logic [15:0]                   flow_draw,
    input  wire logic [9:0]                    erosion_draw,
    output logic                               done,
    output logic [7:0]                         new_own_elevation,
    output logic [7:0]                         new_own_water,
    output logic                               flowed,
    output logic [2:0]                         flow_direction,
    output logic                               eroded,
    output logic                               target_present,
    output logic [7:0]                         target_new_elevation,
    output logic [7:0]                         target_new_water
);
    import twfes_pkg::*;

    logic [EROS_W-1:0] thresh_reg;

    // Stage 1 registers
    logic                         s1_vld_reg;
    logic [DIR_N-1:0][WGT_W-1:0]  s1_wgt_reg;
    logic [DIR_N-1:0][WGT_W-1:0]  s1_wgt_next;
    level_t                       s1_elev_reg;
    level_t                       s1_water_reg;
    logic [DIR_N*ELEV_W-1:0]      s1_nelev_reg;
    logic [DIR_N*ELEV_W-1:0]      s1_nwat_reg;
    logic [DIR_N-1:0]             s1_pres_reg;
    logic                         s1_ero_reg;
    logic [DRAW_W-1:0]            s1_draw_reg;
    level_t                       own_surf;

    // Stage 2 registers
    logic                         s2_vld_reg;
    side_t                        s2_side_reg;
    side_t                        s2_side_next;
    logic [DRAW_W-1:0]            s2_draw_reg;

    // Remainder pipe outputs
    logic                         rp_vld;
    logic [SUM_W-1:0]             rp_rem;
    side_t                        rp_side;

    // Output registers
    logic                         done_reg;
    level_t                       o_elev_reg;
    level_t                       o_water_reg;
    logic                         o_flowed_reg;
    logic [DIR_W-1:0]             o_dir_reg;
    logic                         o_eroded_reg;
    logic                         o_tpres_reg;
    level_t                       o_telev_reg;
    level_t                       o_twat_reg;
    level_t                       o_elev_next;
    level_t                       o_water_next;
    logic                         o_flowed_next;
    logic [DIR_W-1:0]             o_dir_next;
    logic                         o_eroded_next;
    logic                         o_tpres_next;
    level_t                       o_telev_next;
    level_t                       o_twat_next;

    logic [DIR_W-1:0]             pick_dir;
    logic                         pick_has;
    level_t                       pick_elev;
    level_t                       pick_water;
    logic                         pick_erode;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Hold the erosion threshold
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thresh_reg <= erosion_per_mille;
        end
    end

    // Stage 1: direction weights from surface drops
    always_comb
    begin
        level_t nsurf;
        own_surf = sat_surface(own_elevation, own_water);
        for (int d = 0; d < DIR_N; d++)
        begin
            nsurf = sat_surface(neighbour_elevations[d*ELEV_W +: ELEV_W],
                                neighbour_waters[d*ELEV_W +: ELEV_W]);
            if (!neighbour_present[d])
            begin
                s1_wgt_next[d] = WGT_W'(1);
            end
            else if (nsurf <= own_surf)
            begin
                s1_wgt_next[d] = {1'b0, own_surf} - {1'b0, nsurf} + WGT_W'(1);
            end
            else
            begin
                s1_wgt_next[d] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_wgt_reg   <= s1_wgt_next;
        s1_elev_reg  <= own_elevation;
        s1_water_reg <= own_water;
        s1_nelev_reg <= neighbour_elevations;
        s1_nwat_reg  <= neighbour_waters;
        s1_pres_reg  <= neighbour_present;
        s1_ero_reg   <= erosion_draw < thresh_reg;
        s1_draw_reg  <= flow_draw;
    end

    // Stage 2: running weight sums; the last one is the total
    always_comb
    begin
        logic [SUM_W-1:0] run;
        run = '0;
        for (int d = 0; d < DIR_N; d++)
        begin
            run = run + SUM_W'(s1_wgt_reg[d]);
            s2_side_next.cum[d] = run;
        end
        s2_side_next.own_elev  = s1_elev_reg;
        s2_side_next.own_water = s1_water_reg;
        s2_side_next.nbr_elev  = s1_nelev_reg;
        s2_side_next.nbr_water = s1_nwat_reg;
        s2_side_next.present   = s1_pres_reg;
        s2_side_next.ero_ok    = s1_ero_reg;
        s2_side_next.flow_ok   = (s1_water_reg != '0) && (run != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_side_reg <= s2_side_next;
        s2_draw_reg <= s1_draw_reg;
    end

    // Stages 3 to 6: draw modulo total
    twfes_rem_pipe u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_vld_reg),
        .in_num    (s2_draw_reg),
        .in_div    (s2_side_reg.cum[DIR_N-1]),
        .in_side   (s2_side_reg),
        .out_valid (rp_vld),
        .out_rem   (rp_rem),
        .out_side  (rp_side)
    );

    // Stage 7: first direction whose running sum exceeds the remainder
    always_comb
    begin
        pick_dir = DIR_W'(DIR_N - 1);
        for (int d = DIR_N - 1; d >= 0; d--)
        begin
            if (rp_rem < rp_side.cum[d])
            begin
                pick_dir = DIR_W'(d);
            end
        end
        pick_has   = rp_side.present[pick_dir];
        pick_elev  = rp_side.nbr_elev[pick_dir*ELEV_W +: ELEV_W];
        pick_water = rp_side.nbr_water[pick_dir*ELEV_W +: ELEV_W];
        pick_erode = (!pick_has || (pick_elev <= rp_side.own_elev)) &&
                     rp_side.ero_ok && (rp_side.own_elev != '0);
    end

    // Apply the move of water and soil
    always_comb
    begin
        o_elev_next   = rp_side.own_elev;
        o_water_next  = rp_side.own_water;
        o_flowed_next = 1'b0;
        o_dir_next    = '0;
        o_eroded_next = 1'b0;
        o_tpres_next  = 1'b0;
        o_telev_next  = '0;
        o_twat_next   = '0;
        if (rp_side.flow_ok)
        begin
            o_flowed_next = 1'b1;
            o_dir_next    = pick_dir;
            o_water_next  = rp_side.own_water - ELEV_W'(1);
            o_eroded_next = pick_erode;
            if (pick_erode)
            begin
                o_elev_next = rp_side.own_elev - ELEV_W'(1);
            end
            if (pick_has)
            begin
                o_tpres_next = 1'b1;
                o_telev_next = pick_elev;
                o_twat_next  = pick_water;
                if (sat_surface(pick_elev, pick_water) != SAT_MAX)
                begin
                    o_twat_next = pick_water + ELEV_W'(1);
                end
                if (pick_erode && (pick_elev != SAT_MAX))
                begin
                    o_telev_next = pick_elev + ELEV_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= rp_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        o_elev_reg   <= o_elev_next;
        o_water_reg  <= o_water_next;
        o_flowed_reg <= o_flowed_next;
        o_dir_reg    <= o_dir_next;
        o_eroded_reg <= o_eroded_next;
        o_tpres_reg  <= o_tpres_next;
        o_telev_reg  <= o_telev_next;
        o_twat_reg   <= o_twat_next;
    end

    assign done                 = done_reg;
    assign new_own_elevation    = o_elev_reg;
    assign new_own_water        = o_water_reg;
    assign flowed               = o_flowed_reg;
    assign flow_direction       = o_dir_reg;
    assign eroded               = o_eroded_reg;
    assign target_present       = o_tpres_reg;
    assign target_new_elevation = o_telev_reg;
    assign target_new_water     = o_twat_reg;

endmodule

`default_nettype wire

### design/twfes_checker.sv
// ============================================================================
// twfes_checker
// Port-level checks on the tile step: result timing and result consistency.
// ============================================================================
`default_nettype none

module twfes_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic [7:0]  own_water,
    input  wire logic [7:0]  new_own_water,
    input  wire logic        flowed,
    input  wire logic [2:0]  flow_direction,
    input  wire logic        eroded,
    input  wire logic        target_present,
    input  wire logic [7:0]  target_new_elevation,
    input  wire logic [7:0]  target_new_water
);

    // Every accepted beat gives a matching result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 done)
        else $error("accepted beat produced no result");

    // No result without a matching accepted beat
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 7))
        else $error("result without accepted beat");

    // A dry or blocked tile moves nothing
    a_no_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !flowed) |->
            (flow_direction == 3'd0) && !eroded && !target_present)
        else $error("movement reported without flow");

    // Flow takes exactly one unit of water off the tile
    a_water: assert property (@(posedge clk) disable iff (!rst_n)
        (done && flowed) |->
            ({1'b0, new_own_water} + 9'd1 == {1'b0, $past(own_water, 7)}))
        else $error("tile water not reduced by one");

    // An absent target reports zero contents
    a_target: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !target_present) |->
            (target_new_elevation == 8'd0) && (target_new_water == 8'd0))
        else $error("absent target carries data");

endmodule

bind tile_water_flow_erosion_step twfes_checker u_twfes_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .done                 (done),
    .own_water            (own_water),
    .new_own_water        (new_own_water),
    .flowed               (flowed),
    .flow_direction       (flow_direction),
    .eroded               (eroded),
    .target_present       (target_present),
    .target_new_elevation (target_new_elevation),
    .target_new_water     (target_new_water)
);

`default_nettype wire
